/* hw/rtl/cppf_pkg.sv */
// Shared types, widths and constants for the cubic path point and frame core.
// No dependencies; every other file imports this package.
package cppf_pkg;

  function automatic int imax(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

  localparam int SQUARE_FRAC = 36;
  localparam int CUBE_FRAC   = 44;
  localparam int NORM_STEPS  = 3;

  // Rounding shifts of the polynomial terms
  localparam int SH_B  = 30;
  localparam int SH_C  = SQUARE_FRAC + 12;
  localparam int SH_D  = CUBE_FRAC + 24;
  localparam int SH_C2 = SQUARE_FRAC - 18;
  localparam int SH_D3 = CUBE_FRAC - 6;

  // Rounded term magnitude widths
  localparam int TB_W = 65 - SH_B;
  localparam int TC_W = 97 - SH_C;
  localparam int TD_W = 129 - SH_D;
  localparam int T2_W = 66 - SH_C2;
  localparam int T3_W = 99 - SH_D3;

  localparam int UACC_W = imax(imax(TB_W, TC_W), imax(TD_W, 32)) + 3;
  localparam int DER_W  = imax(imax(T2_W, T3_W), 32) + 2;

  // Normaliser word
  localparam int NW    = imax(DER_W, 64);
  localparam int NG    = (NW + 15) / 16;
  localparam int GW    = NG * 16;
  localparam int LEN_W = $clog2(GW + 1);

  localparam int POLY_LAT  = 8;
  localparam int FRAME_LAT = 12 + 3 * NORM_STEPS;
  localparam int POS_DLY   = FRAME_LAT - 1;
  localparam int TOTAL_LAT = POLY_LAT + FRAME_LAT;

  // Register indexes
  localparam logic [2:0] REG_CONST   = 3'd0;
  localparam logic [2:0] REG_LINEAR  = 3'd1;
  localparam logic [2:0] REG_SQUARE  = 3'd2;
  localparam logic [2:0] REG_CUBE    = 3'd3;
  localparam logic [2:0] REG_HEADING = 3'd4;
  localparam logic [2:0] REG_ORIGIN  = 3'd5;
  localparam logic [2:0] REG_START   = 3'd6;

  localparam logic [63:0] HEADING_RESET = 64'h4000_0000_0000_0000;

  // Index [1] is the u (high) half, [0] the v (low) half
  typedef struct packed {
    logic [1:0][31:0] a;
    logic [1:0][31:0] b;
    logic [1:0][31:0] c;
    logic [1:0][31:0] d;
    logic [31:0]      cs;
    logic [31:0]      sn;
    logic [31:0]      x0;
    logic [31:0]      y0;
    logic [31:0]      s0;
  } cfg_t;

  typedef struct packed {
    logic          vld;
    logic [NW-1:0] ma;
    logic [NW-1:0] mb;
    logic          sa;
    logic          sb;
    logic          keep;
  } norm_in_t;

  typedef struct packed {
    logic        vld;
    logic [29:0] a;
    logic [29:0] b;
    logic        sa;
    logic        sb;
    logic        nz;
    logic        keep;
  } norm_out_t;

  // Inverse square root seeds, Q.30, indexed by m >> 28
  function automatic logic [32:0] seed_lut(input logic [2:0] idx);
    logic [32:0] r;
    case (idx)
      3'd0:    r = 33'd1753413056;
      3'd1:    r = 33'd1753413056;
      3'd2:    r = 33'd1358187876;
      3'd3:    r = 33'd1147878293;
      3'd4:    r = 33'd1012333435;
      3'd5:    r = 33'd915690105;
      3'd6:    r = 33'd842312383;
      3'd7:    r = 33'd784150158;
      default: r = 33'd784150158;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/cppf_poly.sv */
// Eight-stage polynomial pipeline: offset, powers of p, rounded terms, u/v and derivatives.
// Depends on cppf_pkg.
module cppf_poly (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [31:0]                      road_s,
  input  cppf_pkg::cfg_t                   cfg,
  output logic                             out_valid,
  output logic [1:0][32:0]                 u,
  output logic [1:0][cppf_pkg::DER_W-1:0]  der
);
  import cppf_pkg::*;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [33:0] tri34(input logic [31:0] m);
    return {2'b00, m} + {1'b0, m, 1'b0};
  endfunction

  logic v1, v2, v3, v4, v5, v6, v7, v8;

  logic signed [32:0] p_c;
  logic sp1, sp2, sp3, sp4, sp5, sp6, sp7;
  logic [31:0] ap1, ap2;

  logic [63:0] p2_2;
  logic [63:0] bp2 [2];
  logic [64:0] c2p2 [2];

  logic [63:0] p3lo3, p3hi3;
  logic [63:0] cl3 [2], ch3 [2];
  logic [65:0] d3l3 [2], d3h3 [2];
  logic [TB_W-1:0] tb3 [2], tb4 [2], tb5 [2], tb6 [2], tb7 [2];
  logic [T2_W-1:0] t23 [2], t24 [2], t25 [2];

  logic [95:0] p3_4;
  logic [95:0] cp4 [2];
  logic [97:0] d3p4 [2];

  logic [63:0] dpk5 [2][3];
  logic [TC_W-1:0] tc5 [2], tc6 [2], tc7 [2];
  logic [T3_W-1:0] t35 [2];

  logic [127:0] dp6 [2];
  logic signed [DER_W-1:0] der6 [2], der7 [2], der8 [2];
  logic [TD_W-1:0] td7 [2];
  logic [32:0] u8 [2];

  logic [64:0] tb_sum [2];
  logic [65:0] t2_sum [2];
  logic [96:0] tc_sum [2];
  logic [98:0] t3_sum [2];
  logic [128:0] td_sum [2];
  logic signed [DER_W-1:0] der_next [2];
  logic signed [DER_W-1:0] e2 [2], e3 [2];
  logic signed [UACC_W-1:0] acc [2], eb [2], ec [2], ed [2];
  logic signed [UACC_W-1:0] u_lim;
  logic [32:0] u_next [2];

  assign p_c = $signed({road_s[31], road_s}) - $signed({cfg.s0[31], cfg.s0});
  assign u_lim = UACC_W'(33'h0_FFFF_FFFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6; v8 <= v7;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      tb_sum[i] = {1'b0, bp2[i]} + (65'd1 << (SH_B - 1));
      t2_sum[i] = {1'b0, c2p2[i]} + (66'd1 << (SH_C2 - 1));
      tc_sum[i] = {1'b0, cp4[i]} + (97'd1 << (SH_C - 1));
      t3_sum[i] = {1'b0, d3p4[i]} + (99'd1 << (SH_D3 - 1));
      td_sum[i] = {1'b0, dp6[i]} + (129'd1 << (SH_D - 1));
      // derivative: b + 2cp + 3dp^2
      e2[i] = DER_W'(t25[i]);
      if (cfg.c[i][31] ^ sp5) e2[i] = -e2[i];
      e3[i] = DER_W'(t35[i]);
      if (cfg.d[i][31]) e3[i] = -e3[i];
      der_next[i] = DER_W'($signed(cfg.b[i])) + e2[i] + e3[i];
      // position: a + bp + cp^2 + dp^3, clamped
      eb[i] = UACC_W'(tb7[i]);
      if (cfg.b[i][31] ^ sp7) eb[i] = -eb[i];
      ec[i] = UACC_W'(tc7[i]);
      if (cfg.c[i][31]) ec[i] = -ec[i];
      ed[i] = UACC_W'(td7[i]);
      if (cfg.d[i][31] ^ sp7) ed[i] = -ed[i];
      acc[i] = UACC_W'($signed(cfg.a[i])) + eb[i] + ec[i] + ed[i];
      if (acc[i] > u_lim)       u_next[i] = 33'h0_FFFF_FFFF;
      else if (acc[i] < -u_lim) u_next[i] = 33'h1_0000_0001;
      else                      u_next[i] = acc[i][32:0];
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: offset from segment start
    sp1 <= p_c[32];
    ap1 <= p_c[32] ? 32'(-p_c) : 32'(p_c);
    // stage 2: p^2, b*p, 2c*p
    sp2  <= sp1;
    ap2  <= ap1;
    p2_2 <= {32'd0, ap1} * {32'd0, ap1};
    for (int i = 0; i < 2; i++) begin
      bp2[i]  <= {32'd0, mag32(cfg.b[i])} * {32'd0, ap1};
      c2p2[i] <= {32'd0, mag32(cfg.c[i]), 1'b0} * {33'd0, ap1};
    end
    // stage 3: partial products on the two halves of p^2
    sp3   <= sp2;
    p3lo3 <= {32'd0, p2_2[31:0]} * {32'd0, ap2};
    p3hi3 <= {32'd0, p2_2[63:32]} * {32'd0, ap2};
    for (int i = 0; i < 2; i++) begin
      cl3[i]  <= {32'd0, mag32(cfg.c[i])} * {32'd0, p2_2[31:0]};
      ch3[i]  <= {32'd0, mag32(cfg.c[i])} * {32'd0, p2_2[63:32]};
      d3l3[i] <= {32'd0, tri34(mag32(cfg.d[i]))} * {34'd0, p2_2[31:0]};
      d3h3[i] <= {32'd0, tri34(mag32(cfg.d[i]))} * {34'd0, p2_2[63:32]};
      tb3[i]  <= tb_sum[i][64:SH_B];
      t23[i]  <= t2_sum[i][65:SH_C2];
    end
    // stage 4: combine partials
    sp4  <= sp3;
    p3_4 <= {p3hi3, 32'd0} + {32'd0, p3lo3};
    for (int i = 0; i < 2; i++) begin
      cp4[i]  <= {ch3[i], 32'd0} + {32'd0, cl3[i]};
      d3p4[i] <= {d3h3[i], 32'd0} + {32'd0, d3l3[i]};
      tb4[i]  <= tb3[i];
      t24[i]  <= t23[i];
    end
    // stage 5: d*p^3 partials, round c and 3d terms
    sp5 <= sp4;
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 3; k++) begin
        dpk5[i][k] <= {32'd0, mag32(cfg.d[i])} * {32'd0, p3_4[32*k +: 32]};
      end
      tc5[i] <= tc_sum[i][96:SH_C];
      t35[i] <= t3_sum[i][98:SH_D3];
      tb5[i] <= tb4[i];
      t25[i] <= t24[i];
    end
    // stage 6: d*p^3, derivative sum
    sp6 <= sp5;
    for (int i = 0; i < 2; i++) begin
      dp6[i]  <= {dpk5[i][2], 64'd0} + {32'd0, dpk5[i][1], 32'd0} + {64'd0, dpk5[i][0]};
      der6[i] <= der_next[i];
      tb6[i]  <= tb5[i];
      tc6[i]  <= tc5[i];
    end
    // stage 7: round cube term
    sp7 <= sp6;
    for (int i = 0; i < 2; i++) begin
      td7[i]  <= td_sum[i][128:SH_D];
      tb7[i]  <= tb6[i];
      tc7[i]  <= tc6[i];
      der7[i] <= der6[i];
    end
    // stage 8: position sum and clamp
    for (int i = 0; i < 2; i++) begin
      u8[i]   <= u_next[i];
      der8[i] <= der7[i];
    end
  end

  assign out_valid = v8;
  assign u[1]   = u8[1];
  assign u[0]   = u8[0];
  assign der[1] = der8[1];
  assign der[0] = der8[0];

endmodule

/* hw/rtl/cppf_norm.sv */
// Three-stage normaliser: scales a magnitude pair so the larger lies in [2^29, 2^30).
// Depends on cppf_pkg.
module cppf_norm (
  input  logic                clk,
  input  logic                rst,
  input  cppf_pkg::norm_in_t  din,
  output cppf_pkg::norm_out_t dout
);
  import cppf_pkg::*;

  logic [GW-1:0] orw;
  logic [NG-1:0] gf_c;
  logic [3:0]    gp_c [NG];

  logic          v1, v2;
  logic [NW-1:0] ma1, mb1, ma2, mb2;
  logic          sa1, sb1, k1, sa2, sb2, k2;
  logic [NG-1:0] gf1;
  logic [3:0]    gp1 [NG];
  logic [LEN_W-1:0] len_c, len2;
  logic [NW+29:0] sha, shb;

  assign orw = GW'(din.ma | din.mb);

  // leading one inside each 16-bit group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gf_c[g] = |orw[16*g +: 16];
      gp_c[g] = 4'd0;
      for (int j = 0; j < 16; j++) begin
        if (orw[16*g + j]) gp_c[g] = 4'(j);
      end
    end
  end

  always_comb begin
    len_c = '0;
    for (int g = 0; g < NG; g++) begin
      if (gf1[g]) len_c = LEN_W'(16 * g) + LEN_W'(gp1[g]) + LEN_W'(1);
    end
  end

  assign sha = {ma2, 30'd0} >> len2;
  assign shb = {mb2, 30'd0} >> len2;

  always_ff @(posedge clk) begin
    ma1 <= din.ma; mb1 <= din.mb;
    sa1 <= din.sa; sb1 <= din.sb; k1 <= din.keep;
    gf1 <= gf_c;
    for (int g = 0; g < NG; g++) gp1[g] <= gp_c[g];
    ma2 <= ma1; mb2 <= mb1;
    sa2 <= sa1; sb2 <= sb1; k2 <= k1;
    len2 <= len_c;
    dout.a    <= sha[29:0];
    dout.b    <= shb[29:0];
    dout.sa   <= sa2;
    dout.sb   <= sb2;
    dout.keep <= k2;
    dout.nz   <= (len2 != '0);
    dout.vld  <= v2 && !rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= din.vld;
      v2 <= v1;
    end
  end

endmodule

/* hw/rtl/cppf_frame.sv */
// Frame pipeline: heading rotation of the point, tangent scaling, rotation and Newton
// inverse square root, final rounding. Depends on cppf_pkg and cppf_norm.
module cppf_frame (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [1:0][32:0]                u,
  input  logic [1:0][cppf_pkg::DER_W-1:0] der,
  input  cppf_pkg::cfg_t                  cfg,
  output logic                            out_valid,
  output logic [31:0]                     pos_x,
  output logic [31:0]                     pos_y,
  output logic [31:0]                     tangent_x,
  output logic [31:0]                     tangent_y,
  output logic [31:0]                     normal_x,
  output logic [31:0]                     normal_y
);
  import cppf_pkg::*;

  typedef struct packed {
    logic               vld;
    logic               zf;
    logic [30:0]        m;
    logic signed [30:0] tx;
    logic signed [30:0] ty;
    logic [32:0]        r;
    logic [33:0]        t;
  } newt_t;

  // round half away from zero, Q.30 down
  function automatic logic signed [35:0] rnd30(input logic signed [64:0] x);
    logic [64:0] m;
    logic [34:0] q;
    m = x[64] ? 65'(-x) : 65'(x);
    m = m + 65'd536870912;
    q = m[64:30];
    return x[64] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic [31:0] sat32(input logic signed [39:0] x);
    if (x > 40'sd2147483647)       return 32'h7FFF_FFFF;
    else if (x < -40'sd2147483648) return 32'h8000_0000;
    else                           return x[31:0];
  endfunction

  // point rotation
  logic signed [64:0] prcu, prsv, prsu, prcv;
  logic [31:0] pos_line_x [POS_DLY];
  logic [31:0] pos_line_y [POS_DLY];

  // tangent path
  logic [DER_W-1:0] dmag [2];
  norm_in_t  n1_in, n2_in;
  norm_out_t n1_out, n2_out;
  logic signed [30:0] xs_c, ys_c;
  logic signed [62:0] pcx, psy, psx, pcy;
  logic v4, k4;
  logic signed [63:0] rx_c, ry_c;
  logic [59:0] aa9, bb9;
  logic signed [30:0] xq9, yq9;
  logic v9, zf9;
  logic [61:0] msum;
  newt_t ns [0:3*NORM_STEPS];
  logic signed [64:0] txp, typ;
  logic va, zfa;
  logic [31:0] tyc;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dmag[i] = der[i][DER_W-1] ? (~der[i] + DER_W'(1)) : der[i];
    end
  end

  assign n1_in.vld  = in_valid;
  assign n1_in.ma   = NW'(dmag[1]);
  assign n1_in.mb   = NW'(dmag[0]);
  assign n1_in.sa   = der[1][DER_W-1];
  assign n1_in.sb   = der[0][DER_W-1];
  assign n1_in.keep = 1'b1;

  cppf_norm u_norm_der (
    .clk  (clk),
    .rst  (rst),
    .din  (n1_in),
    .dout (n1_out)
  );

  assign xs_c = n1_out.sa ? -$signed({1'b0, n1_out.a}) : $signed({1'b0, n1_out.a});
  assign ys_c = n1_out.sb ? -$signed({1'b0, n1_out.b}) : $signed({1'b0, n1_out.b});
  assign rx_c = pcx - psy;
  assign ry_c = psx + pcy;

  cppf_norm u_norm_rot (
    .clk  (clk),
    .rst  (rst),
    .din  (n2_in),
    .dout (n2_out)
  );

  assign msum = {2'b00, aa9} + {2'b00, bb9} + 62'd536870912;

  always_ff @(posedge clk) begin
    // point: rotate (u, v) and add origin
    prcu <= $signed(cfg.cs) * $signed(u[1]);
    prsv <= $signed(cfg.sn) * $signed(u[0]);
    prsu <= $signed(cfg.sn) * $signed(u[1]);
    prcv <= $signed(cfg.cs) * $signed(u[0]);
    pos_line_x[0] <= sat32(40'($signed(cfg.x0)) + 40'(rnd30(prcu)) - 40'(rnd30(prsv)));
    pos_line_y[0] <= sat32(40'($signed(cfg.y0)) + 40'(rnd30(prsu)) + 40'(rnd30(prcv)));
    for (int k = 1; k < POS_DLY; k++) begin
      pos_line_x[k] <= pos_line_x[k-1];
      pos_line_y[k] <= pos_line_y[k-1];
    end
    // tangent rotation
    pcx <= $signed(cfg.cs) * xs_c;
    psy <= $signed(cfg.sn) * ys_c;
    psx <= $signed(cfg.sn) * xs_c;
    pcy <= $signed(cfg.cs) * ys_c;
    k4  <= n1_out.nz;
    n2_in.ma   <= NW'(rx_c[63] ? 63'(-rx_c) : 63'(rx_c));
    n2_in.mb   <= NW'(ry_c[63] ? 63'(-ry_c) : 63'(ry_c));
    n2_in.sa   <= rx_c[63];
    n2_in.sb   <= ry_c[63];
    n2_in.keep <= k4;
    // squared length
    aa9 <= {30'd0, n2_out.a} * {30'd0, n2_out.a};
    bb9 <= {30'd0, n2_out.b} * {30'd0, n2_out.b};
    xq9 <= n2_out.sa ? -$signed({1'b0, n2_out.a}) : $signed({1'b0, n2_out.a});
    yq9 <= n2_out.sb ? -$signed({1'b0, n2_out.b}) : $signed({1'b0, n2_out.b});
    zf9 <= !(n2_out.nz && n2_out.keep);
    // seed
    ns[0].m  <= msum[60:30];
    ns[0].r  <= seed_lut(msum[60:58]);
    ns[0].t  <= '0;
    ns[0].tx <= xq9;
    ns[0].ty <= yq9;
    ns[0].zf <= zf9;
    ns[0].vld <= v9 && !rst;
    // final scale by r
    txp <= ns[3*NORM_STEPS].tx * $signed({1'b0, ns[3*NORM_STEPS].r});
    typ <= ns[3*NORM_STEPS].ty * $signed({1'b0, ns[3*NORM_STEPS].r});
    zfa <= ns[3*NORM_STEPS].zf;
    // outputs
    tangent_x <= zfa ? 32'd0 : sat32(40'(rnd30(txp)));
    tangent_y <= tyc;
    normal_x  <= sat32(-40'($signed(tyc)));
    normal_y  <= zfa ? 32'd0 : sat32(40'(rnd30(txp)));
  end

  assign tyc = zfa ? 32'd0 : sat32(40'(rnd30(typ)));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0; n2_in.vld <= 1'b0; v9 <= 1'b0; va <= 1'b0; out_valid <= 1'b0;
    end else begin
      v4 <= n1_out.vld;
      n2_in.vld <= v4;
      v9 <= n2_out.vld;
      va <= ns[3*NORM_STEPS].vld;
      out_valid <= va;
    end
  end

  // Newton steps r = r (3 - m r^2) / 2, three stages each, 64-bit wrapping products
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_newt
    logic [63:0] rr, rr_s, mq, mq_s, rf, rf_s;
    logic [31:0] f;
    logic [32:0] rn;
    newt_t qa, wb, rc;

    assign rr   = {31'd0, ns[3*k].r} * {31'd0, ns[3*k].r};
    assign rr_s = rr + 64'd536870912;
    assign mq   = {33'd0, ns[3*k+1].m} * {30'd0, ns[3*k+1].t};
    assign mq_s = mq + 64'd536870912;
    assign f    = (ns[3*k+2].t < 34'd3221225472) ? 32'(34'd3221225472 - ns[3*k+2].t) : 32'd0;
    assign rf   = {31'd0, ns[3*k+2].r} * {32'd0, f};
    assign rf_s = rf + 64'd1073741824;
    assign rn   = (rf_s[63:31] > 33'h1_0000_0000) ? 33'h1_0000_0000 : rf_s[63:31];

    // valid bits cleared in reset
    always_comb begin
      qa = ns[3*k];
      qa.t = rr_s[63:30];
      qa.vld = ns[3*k].vld && !rst;
      wb = ns[3*k+1];
      wb.t = mq_s[63:30];
      wb.vld = ns[3*k+1].vld && !rst;
      rc = ns[3*k+2];
      rc.r = rn;
      rc.vld = ns[3*k+2].vld && !rst;
    end

    always_ff @(posedge clk) begin
      ns[3*k+1] <= qa;
      ns[3*k+2] <= wb;
      ns[3*k+3] <= rc;
    end
  end

  assign pos_x = pos_line_x[POS_DLY-1];
  assign pos_y = pos_line_y[POS_DLY-1];

endmodule

/* hw/rtl/cubic_path_point_and_frame_core.sv */
// Top level of the cubic path point and frame core: register bank and pipeline.
// Depends on cppf_pkg, cppf_poly, cppf_norm and cppf_frame.
//
//  channel   signals                                   dir   transfer
//  -------   ----------------------------------------  ----  --------------------------
//  input     start, busy, road_s                       in    start && !busy
//  result    done, pos_x/y, tangent_x/y, normal_x/y    out   done, one cycle, no stall
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in    cfg_valid && cfg_ready
//
// One item may enter every cycle; results leave in the order their items were taken, after
// 8 polynomial stages, 6 normaliser stages, 3 per Newton step of the inverse square root,
// plus rotation and rounding stages.
// Synchronous reset empties the pipeline; busy and !cfg_ready follow rst.
// The pipeline never stalls: results are strobed for one cycle and not held.
module cubic_path_point_and_frame_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] road_s,
  output logic        done,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [31:0] tangent_x,
  output logic [31:0] tangent_y,
  output logic [31:0] normal_x,
  output logic [31:0] normal_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import cppf_pkg::*;

  logic [63:0] coef_const, coef_linear, coef_square, coef_cube;
  logic [63:0] heading_rotation, origin_point;
  logic [31:0] start_s;

  cfg_t cfg;
  logic accept;
  logic poly_valid;
  logic [1:0][32:0]      poly_u;
  logic [1:0][DER_W-1:0] poly_der;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  // register bank; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_const       <= '0;
      coef_linear      <= '0;
      coef_square      <= '0;
      coef_cube        <= '0;
      heading_rotation <= HEADING_RESET;
      origin_point     <= '0;
      start_s          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CONST:   coef_const       <= cfg_data;
        REG_LINEAR:  coef_linear      <= cfg_data;
        REG_SQUARE:  coef_square      <= cfg_data;
        REG_CUBE:    coef_cube        <= cfg_data;
        REG_HEADING: heading_rotation <= cfg_data;
        REG_ORIGIN:  origin_point     <= cfg_data;
        REG_START:   start_s          <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // high half is u / cosine / x, low half v / sine / y
  assign cfg.a  = coef_const;
  assign cfg.b  = coef_linear;
  assign cfg.c  = coef_square;
  assign cfg.d  = coef_cube;
  assign cfg.cs = heading_rotation[63:32];
  assign cfg.sn = heading_rotation[31:0];
  assign cfg.x0 = origin_point[63:32];
  assign cfg.y0 = origin_point[31:0];
  assign cfg.s0 = start_s;

  cppf_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .road_s    (road_s),
    .cfg       (cfg),
    .out_valid (poly_valid),
    .u         (poly_u),
    .der       (poly_der)
  );

  cppf_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (poly_valid),
    .u         (poly_u),
    .der       (poly_der),
    .cfg       (cfg),
    .out_valid (done),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .tangent_x (tangent_x),
    .tangent_y (tangent_y),
    .normal_x  (normal_x),
    .normal_y  (normal_y)
  );

  // every item comes out as a result, and no result comes out without an item
  a_item_out: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##TOTAL_LAT done)
    else $error("item lost in pipeline");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, TOTAL_LAT))
    else $error("result without item");

  a_normal_left: assert property (@(posedge clk) disable iff (rst)
    done |-> normal_y == tangent_x)
    else $error("normal not a left quarter turn");

  a_zero_frame: assert property (@(posedge clk) disable iff (rst)
    done && tangent_x == 32'd0 && tangent_y == 32'd0 |-> normal_x == 32'd0)
    else $error("zero tangent with nonzero normal");

endmodule
